// File: hdl/double_hash_table_engine_assert.svh
// Assertion macros used by the hash table engine.
`ifndef DOUBLE_HASH_TABLE_ENGINE_ASSERT_SVH
`define DOUBLE_HASH_TABLE_ENGINE_ASSERT_SVH

// Assert that a condition implies a second condition on the same edge.
`define DHT_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// Assert that a condition implies a second condition on the next edge.
`define DHT_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

// File: hdl/dht_pkg.sv
package dht_pkg;

    localparam int KEY_BITS = 32;
    localparam int CFG_BITS = 11;
    localparam int SLOT_BITS = 10;

    localparam logic [KEY_BITS-1:0] KEY_FREE = '0;
    localparam logic [KEY_BITS-1:0] KEY_DELETED = '1;

    localparam logic [0:0] CFG_TABLE_SIZE = 1'b0;
    localparam logic [0:0] CFG_MIN_FREE = 1'b1;

    typedef enum logic [1:0] {
        MODE_LOOKUP = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_DELETE = 2'd2,
        MODE_SPARE = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_DONE = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_PRESENT = 3'd2,
        ST_FULL = 3'd3,
        ST_BAD_KEY = 3'd4
    } status_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [31:0] key;
        logic [31:0] write_value;
    } in_word_t;

    typedef struct packed {
        logic [2:0] status;
        logic [31:0] read_value;
        logic [9:0] slot;
        logic rehash_needed;
    } out_word_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_MOD1,
        S_MOD2,
        S_READ,
        S_CHECK,
        S_STEP,
        S_WRITE,
        S_DONE
    } state_t;

    typedef struct packed {
        logic start;
        logic [31:0] dividend;
    } div_req_t;

endpackage

// File: hdl/dht_divider.sv
module dht_divider
    import dht_pkg::*;
#(
    parameter int DIV_BITS = 11
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  div_req_t            req,
    input  logic [DIV_BITS-1:0] divisor,
    output logic                done,
    output logic [DIV_BITS-1:0] remainder
);

    localparam int CNT_BITS = $clog2(KEY_BITS + 1);

    logic [KEY_BITS-1:0] quot_reg, quot_next;
    logic [DIV_BITS:0]   rem_reg, rem_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [DIV_BITS:0]   trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg <= rem_next;
    end

    always_comb
    begin
        quot_next = quot_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {rem_reg[DIV_BITS-1:0], quot_reg[KEY_BITS-1]};
        if (req.start)
        begin
            quot_next = req.dividend;
            rem_next = '0;
            cnt_next = CNT_BITS'(KEY_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quot_next = {quot_reg[KEY_BITS-2:0], 1'b0};
            if (trial >= {1'b0, divisor})
                rem_next = trial - {1'b0, divisor};
            else
                rem_next = trial;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign remainder = rem_reg[DIV_BITS-1:0];

endmodule

// File: hdl/double_hash_table_engine.sv
// Channel   Handshake          Payload
// command   start / busy       cmd (mode, key, write_value)
// result    result_valid       result (status, read_value, slot, rehash_needed)
// config    cfg_we             cfg_index, cfg_data
// An item takes two remainder passes of the bit-serial divider, then probes the table:
// each probe reads and checks a slot, and each further probe first steps the index.
// A new command is taken once the result strobe falls; a reserved key skips the divider.
// After reset and after every table_size write taken while idle or clearing, a pass
// clears all SLOTS entries with busy high. The result strobe is high for one cycle;
// it cannot stall.
module double_hash_table_engine
    import dht_pkg::*;
#(
    parameter int SLOTS = 1024,
    parameter int VALUE_BITS = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  in_word_t            cmd,
    output logic                result_valid,
    output out_word_t           result,
    input  logic                cfg_we,
    input  logic [0:0]          cfg_index,
    input  logic [CFG_BITS-1:0] cfg_data
);

    `include "double_hash_table_engine_assert.svh"

    localparam int IDX_BITS = $clog2(SLOTS);
    localparam int SZ_BITS = IDX_BITS + 1;

    logic [KEY_BITS-1:0]   key_mem [SLOTS];
    logic [VALUE_BITS-1:0] val_mem [SLOTS];

    state_t state_reg, state_next;
    logic [CFG_BITS-1:0] size_cfg_reg, size_cfg_next;
    logic [CFG_BITS-1:0] min_free_reg, min_free_next;
    logic [CFG_BITS-1:0] free_reg, free_next;
    logic [CFG_BITS-1:0] del_reg, del_next;
    logic [SZ_BITS-1:0]  size_reg, size_next;
    logic [IDX_BITS-1:0] idx_reg, idx_next;
    logic [IDX_BITS-1:0] step_reg, step_next;
    logic [SZ_BITS-1:0]  cnt_reg, cnt_next;
    logic [1:0]          mode_reg, mode_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [31:0]         wval_reg, wval_next;
    logic                valid_reg, valid_next;
    out_word_t           res_reg, res_next;
    logic [KEY_BITS-1:0]   rd_key_reg;
    logic [VALUE_BITS-1:0] rd_val_reg;
    logic                mem_we;
    logic [KEY_BITS-1:0] mem_wkey;
    logic                val_we;

    div_req_t            div_req;
    logic [SZ_BITS-1:0]  div_divisor;
    logic                div_done;
    logic [SZ_BITS-1:0]  div_rem;
    logic [SZ_BITS:0]    sum;
    logic [SZ_BITS-1:0]  eff_size;
    logic                pass_del;
    logic                stop;
    logic                is_ins;
    logic [CFG_BITS-1:0] free_after;
    logic [CFG_BITS-1:0] del_after;

    dht_divider #(.DIV_BITS(SZ_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .req(div_req), .divisor(div_divisor),
        .done(div_done), .remainder(div_rem)
    );

    always_comb
    begin
        if (size_cfg_reg < CFG_BITS'(3))
            eff_size = SZ_BITS'(3);
        else if ({{(32-CFG_BITS){1'b0}}, size_cfg_reg} > 32'(SLOTS))
            eff_size = SZ_BITS'(SLOTS);
        else
            eff_size = SZ_BITS'(size_cfg_reg);
    end

    always_ff @(posedge clk)
    begin
        rd_key_reg <= key_mem[idx_reg];
        rd_val_reg <= val_mem[idx_reg];
        if (mem_we)
            key_mem[idx_reg] <= mem_wkey;
        if (val_we)
            val_mem[idx_reg] <= VALUE_BITS'(wval_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            size_cfg_reg <= CFG_BITS'(1021);
            min_free_reg <= CFG_BITS'(205);
            free_reg <= '0;
            del_reg <= '0;
            idx_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            size_cfg_reg <= size_cfg_next;
            min_free_reg <= min_free_next;
            free_reg <= free_next;
            del_reg <= del_next;
            idx_reg <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        size_reg <= size_next;
        step_reg <= step_next;
        cnt_reg <= cnt_next;
        mode_reg <= mode_next;
        key_reg <= key_next;
        wval_reg <= wval_next;
        res_reg <= res_next;
    end

    assign is_ins = (mode_reg == MODE_INSERT);
    assign pass_del = !is_ins;
    assign sum = {1'b0, {1'b0, idx_reg}} + {2'b0, step_reg};
    assign free_after = (free_reg != '0) ? free_reg - 1'b1 : free_reg;
    assign del_after = (del_reg != '0) ? del_reg - 1'b1 : del_reg;

    always_comb
    begin
        if (rd_key_reg == KEY_FREE)
            stop = 1'b1;
        else if (rd_key_reg == KEY_DELETED)
            stop = !pass_del;
        else
            stop = (rd_key_reg == key_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        size_cfg_next = size_cfg_reg;
        min_free_next = min_free_reg;
        free_next = free_reg;
        del_next = del_reg;
        size_next = size_reg;
        idx_next = idx_reg;
        step_next = step_reg;
        cnt_next = cnt_reg;
        mode_next = mode_reg;
        key_next = key_reg;
        wval_next = wval_reg;
        valid_next = 1'b0;
        res_next = res_reg;
        mem_we = 1'b0;
        mem_wkey = KEY_FREE;
        val_we = 1'b0;
        div_req.start = 1'b0;
        div_req.dividend = key_reg;
        div_divisor = size_reg;

        if (cfg_we && cfg_index == CFG_MIN_FREE)
            min_free_next = cfg_data;

        case (state_reg)
            S_IDLE:
            begin
                if (cfg_we && cfg_index == CFG_TABLE_SIZE)
                begin
                    size_cfg_next = cfg_data;
                    idx_next = '0;
                    state_next = S_CLEAR;
                end
                else if (start && !valid_reg)
                begin
                    mode_next = cmd.mode;
                    key_next = cmd.key;
                    wval_next = cmd.write_value;
                    size_next = eff_size;
                    res_next = '0;
                    if (cmd.key == KEY_FREE || cmd.key == KEY_DELETED)
                    begin
                        res_next.status = ST_BAD_KEY;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        div_req.start = 1'b1;
                        div_req.dividend = cmd.key;
                        state_next = S_MOD1;
                    end
                end
            end
            S_CLEAR:
            begin
                mem_we = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (cfg_we && cfg_index == CFG_TABLE_SIZE)
                begin
                    size_cfg_next = cfg_data;
                    idx_next = '0;
                end
                else if (idx_reg == IDX_BITS'(SLOTS - 1))
                begin
                    free_next = CFG_BITS'(eff_size);
                    del_next = '0;
                    state_next = S_IDLE;
                end
            end
            S_MOD1:
            begin
                if (div_done)
                begin
                    idx_next = div_rem[IDX_BITS-1:0];
                    div_req.start = 1'b1;
                    div_req.dividend = {key_reg[15:0], key_reg[31:16]};
                    state_next = S_MOD2;
                end
            end
            S_MOD2:
            begin
                div_divisor = size_reg - 1'b1;
                if (div_done)
                begin
                    step_next = IDX_BITS'(div_rem + 1'b1);
                    cnt_next = size_reg;
                    state_next = S_READ;
                end
            end
            S_READ:
                state_next = S_CHECK;
            S_CHECK:
            begin
                if (stop)
                begin
                    res_next.slot = SLOT_BITS'(idx_reg);
                    state_next = S_DONE;
                    if (rd_key_reg == key_reg)
                    begin
                        if (is_ins)
                            res_next.status = ST_PRESENT;
                        else if (mode_reg == MODE_DELETE)
                        begin
                            res_next.status = ST_DONE;
                            mem_we = 1'b1;
                            mem_wkey = KEY_DELETED;
                            if (del_reg != '1)
                                del_next = del_reg + 1'b1;
                        end
                        else
                        begin
                            res_next.status = ST_DONE;
                            res_next.read_value = 32'(rd_val_reg);
                        end
                    end
                    else if (is_ins)
                    begin
                        res_next.status = ST_DONE;
                        mem_we = 1'b1;
                        mem_wkey = key_reg;
                        val_we = 1'b1;
                        if (rd_key_reg == KEY_FREE)
                            free_next = free_after;
                        else
                            del_next = del_after;
                    end
                    else
                    begin
                        res_next.status = ST_NOT_FOUND;
                        res_next.slot = '0;
                    end
                end
                else if (cnt_reg == '0)
                begin
                    res_next.status = is_ins ? ST_FULL : ST_NOT_FOUND;
                    state_next = S_DONE;
                end
                else
                    state_next = S_STEP;
            end
            S_STEP:
            begin
                if (sum >= {1'b0, size_reg})
                    idx_next = IDX_BITS'(sum - {1'b0, size_reg});
                else
                    idx_next = IDX_BITS'(sum);
                cnt_next = cnt_reg - 1'b1;
                state_next = S_READ;
            end
            S_DONE:
            begin
                valid_next = 1'b1;
                res_next.rehash_needed = (free_reg < min_free_reg) ||
                                         (del_reg > min_free_reg);
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign busy = (state_reg != S_IDLE) || valid_reg;
    assign result_valid = valid_reg;
    assign result = res_reg;

    `DHT_ASSERT_IMP(a_busy_on_result, clk, rst_n, result_valid, busy)
    `DHT_ASSERT_NEXT(a_start_taken, clk, rst_n,
        start && !busy && !cfg_we, busy)
    `DHT_ASSERT_IMP(a_counts_bounded, clk, rst_n, state_reg == S_IDLE,
        free_reg <= CFG_BITS'(SLOTS))

endmodule

// File: tb/tb_double_hash_table_engine.sv
`timescale 1ns / 1ps

module tb_double_hash_table_engine;
    import dht_pkg::*;

    localparam int SLOTS = 1024;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    in_word_t            cmd;
    logic                result_valid;
    out_word_t           result;
    logic                cfg_we;
    logic [0:0]          cfg_index;
    logic [CFG_BITS-1:0] cfg_data;

    in_word_t  pending_cmds[$];
    out_word_t expected_results[$];
    bit [31:0] key_pool[$];

    bit [31:0] tbl_keys[SLOTS];
    bit [31:0] tbl_values[SLOTS];
    bit [31:0] free_slots;
    bit [31:0] deleted_slots;
    bit [10:0] size_reg;
    bit [10:0] floor_reg;

    bit     sent;
    int     gap_left;
    bit     calm;
    int     failures;

    double_hash_table_engine uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .cmd(cmd),
        .result_valid(result_valid),
        .result(result),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit [31:0] table_slots();
        if (size_reg < 3)
            return 3;
        if (size_reg > SLOTS)
            return SLOTS;
        return size_reg;
    endfunction

    function automatic void clear_table();
        for (int i = 0; i < SLOTS; i++)
        begin
            tbl_keys[i] = KEY_FREE;
            tbl_values[i] = '0;
        end
        free_slots = table_slots();
        deleted_slots = 0;
    endfunction

    function automatic bit stops_at(bit [31:0] idx, bit [31:0] key, bit pass_deleted);
        if (tbl_keys[idx] == KEY_FREE)
            return 1'b1;
        if (tbl_keys[idx] == KEY_DELETED)
            return !pass_deleted;
        return tbl_keys[idx] == key;
    endfunction

    function automatic bit probe_chain(bit [31:0] key, bit pass_deleted,
                                       output bit [31:0] where);
        bit [31:0] s;
        bit [31:0] idx;
        bit [31:0] stride;
        s = table_slots();
        idx = key % s;
        where = 0;
        if (stops_at(idx, key, pass_deleted))
        begin
            where = idx;
            return 1'b1;
        end
        stride = {key[15:0], key[31:16]} % (s - 1) + 1;
        for (int n = 0; n < s; n++)
        begin
            idx = idx + stride;
            if (idx >= s)
                idx = idx - s;
            if (stops_at(idx, key, pass_deleted))
            begin
                where = idx;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic out_word_t hash_table_apply(in_word_t w);
        out_word_t r;
        bit [31:0] at;
        bit        hit;
        r.status = ST_NOT_FOUND;
        r.read_value = '0;
        r.slot = '0;
        if (w.key == KEY_FREE || w.key == KEY_DELETED)
        begin
            r.status = ST_BAD_KEY;
        end
        else if (w.mode == MODE_INSERT)
        begin
            hit = probe_chain(w.key, 1'b0, at);
            if (!hit)
                r.status = ST_FULL;
            else if (tbl_keys[at] == w.key)
            begin
                r.status = ST_PRESENT;
                r.slot = at[9:0];
            end
            else
            begin
                if (tbl_keys[at] == KEY_FREE)
                begin
                    if (free_slots > 0)
                        free_slots--;
                end
                else if (deleted_slots > 0)
                    deleted_slots--;
                tbl_keys[at] = w.key;
                tbl_values[at] = w.write_value;
                r.status = ST_DONE;
                r.slot = at[9:0];
            end
        end
        else
        begin
            hit = probe_chain(w.key, 1'b1, at);
            if (hit && tbl_keys[at] != KEY_FREE)
            begin
                r.status = ST_DONE;
                r.slot = at[9:0];
                if (w.mode == MODE_DELETE)
                begin
                    tbl_keys[at] = KEY_DELETED;
                    if (deleted_slots < 11'h7FF)
                        deleted_slots++;
                end
                else
                    r.read_value = tbl_values[at];
            end
        end
        r.rehash_needed = (free_slots < floor_reg) || (deleted_slots > floor_reg);
        return r;
    endfunction

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!start || sent)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    start <= 1'b0;
                end
                else if (pending_cmds.size() > 0)
                begin
                    start <= 1'b1;
                    cmd <= pending_cmds.pop_front();
                    if (!calm && $urandom_range(0, 3) == 0)
                        gap_left <= $urandom_range(1, 9);
                end
                else
                    start <= 1'b0;
            end
            sent = 1'b0;
        end
    end

    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                expected_results.push_back(hash_table_apply(cmd));
                sent = 1'b1;
            end
            if (result_valid)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result word");
                    failures++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result.status !== want.status)
                    begin
                        $error("status expected %0d got %0d", want.status, result.status);
                        failures++;
                    end
                    if (result.read_value !== want.read_value)
                    begin
                        $error("read_value expected %h got %h",
                               want.read_value, result.read_value);
                        failures++;
                    end
                    if (result.slot !== want.slot)
                    begin
                        $error("slot expected %0d got %0d", want.slot, result.slot);
                        failures++;
                    end
                    if (result.rehash_needed !== want.rehash_needed)
                    begin
                        $error("rehash_needed expected %0d got %0d",
                               want.rehash_needed, result.rehash_needed);
                        failures++;
                    end
                end
            end
        end
    end

    task automatic send(mode_t m, bit [31:0] k, bit [31:0] v);
        in_word_t w;
        w.mode = m;
        w.key = k;
        w.write_value = v;
        pending_cmds.push_back(w);
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_cmds.size() != 0 || expected_results.size() != 0 || start || busy);
        repeat (5) @(posedge clk);
    endtask

    task automatic write_reg(logic [0:0] idx, bit [10:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_TABLE_SIZE)
        begin
            size_reg = value;
            clear_table();
        end
        else
            floor_reg = value;
        repeat (2) @(negedge clk);
    endtask

    task automatic random_phase(int count);
        bit [31:0] k;
        int        pool_n;
        int        pick;
        pool_n = table_slots() * 2 + 2;
        if (pool_n > 300)
            pool_n = 300;
        key_pool.delete();
        for (int i = 0; i < pool_n; i++)
        begin
            k = $urandom;
            if (k == KEY_FREE || k == KEY_DELETED)
                k = 32'h1234_5678;
            key_pool.push_back(k);
        end
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
                k = $urandom_range(0, 1) ? KEY_DELETED : KEY_FREE;
            else if (pick < 8)
                k = $urandom;
            else
                k = key_pool[$urandom_range(0, pool_n - 1)];
            pick = $urandom_range(0, 99);
            if (pick < 45)
                send(MODE_INSERT, k, $urandom);
            else if (pick < 75)
                send(MODE_LOOKUP, k, $urandom);
            else if (pick < 97)
                send(MODE_DELETE, k, $urandom);
            else
                send(MODE_SPARE, k, $urandom);
        end
    endtask

    initial
    begin
        bit [10:0] sizes[11];
        bit [10:0] floors[11];
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        sent = 1'b0;
        gap_left = 0;
        calm = 1'b0;
        failures = 0;
        size_reg = 1021;
        floor_reg = 205;
        clear_table();
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        send(MODE_LOOKUP, 32'd1, 32'd0);
        send(MODE_INSERT, 32'd1, 32'd0);
        send(MODE_INSERT, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
        send(MODE_INSERT, 32'd1, 32'hAAAA_5555);
        send(MODE_LOOKUP, 32'd1, 32'd0);
        send(MODE_LOOKUP, 32'hFFFF_FFFE, 32'd0);
        send(MODE_SPARE, 32'hFFFF_FFFE, 32'd0);
        send(MODE_DELETE, 32'd1, 32'd0);
        send(MODE_DELETE, 32'd1, 32'd0);
        send(MODE_LOOKUP, 32'd1, 32'd0);
        send(MODE_LOOKUP, KEY_FREE, 32'd0);
        send(MODE_INSERT, KEY_FREE, 32'd7);
        send(MODE_DELETE, KEY_DELETED, 32'd0);
        send(MODE_INSERT, KEY_DELETED, 32'd7);
        send(MODE_INSERT, 32'd1021, 32'h5555_AAAA);
        send(MODE_INSERT, 32'd2042, 32'h0F0F_0F0F);
        send(MODE_DELETE, 32'd1021, 32'd0);
        send(MODE_INSERT, 32'd2042, 32'hF0F0_F0F0);
        send(MODE_LOOKUP, 32'd2042, 32'd0);
        send(MODE_DELETE, 32'd2042, 32'd0);
        send(MODE_LOOKUP, 32'd2042, 32'd0);
        wait_drained();

        sizes  = '{11'd3, 11'd0, 11'd2, 11'd7, 11'd13, 11'd1024, 11'd2047,
                   11'd61, 11'd97, 11'd1021, 11'd31};
        floors = '{11'd1, 11'd2047, 11'd1, 11'd3, 11'd0, 11'd1024, 11'd1,
                   11'd10, 11'd30, 11'd205, 11'd5};
        for (int p = 0; p < 11; p++)
        begin
            write_reg(CFG_TABLE_SIZE, sizes[p]);
            write_reg(CFG_MIN_FREE, floors[p]);
            if (p == 10)
                calm = 1'b1;
            random_phase(130);
            wait_drained();
        end

        repeat (20) @(posedge clk);
        if (failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #200ms;
        $display("status: fail");
        $finish;
    end

endmodule
